// ===== hw/rtl/atat_pkg.sv =====
// Package for the averaged accelerometer tilt angle unit.
// Holds the widths, the fixed-point constants, the arctangent table and the lane types.
// No dependencies; every module of the unit imports it.
package atat_pkg;

    // Sample and result formats
    localparam int SAMPLE_W    = 16;
    localparam int ANGLE_W     = 16;
    localparam int SUM_W       = 20;
    localparam int CFG_W       = 5;
    localparam int CFG_RESET   = 10;
    localparam int MAX_SAMPLES = 16;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // CORDIC formats: operands are sums times 256, angle in 1/65536 degree
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int OPER_SHIFT   = 8;
    localparam int CORDIC_W     = 32;
    localparam int Z_W          = 26;
    localparam int DEG180       = 180 * 65536;
    localparam int ROUND_BIAS   = 256;
    localparam int ROUND_SHIFT  = 9;
    localparam int ANGLE_LIMIT  = 23040;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    localparam int TABLE_LEN   = 24;
    localparam int TABLE_IDX_W = $clog2(TABLE_LEN);
    localparam int AtanTable [TABLE_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // Lane sequencer states
    typedef enum logic [1:0] {
        LANE_IDLE,
        LANE_RUN,
        LANE_DONE
    } atat_lane_state_t;

    // Status a lane reports to the top level and the merge stage
    typedef struct packed {
        logic busy;
        logic done;
    } atat_lane_status_t;

endpackage

// ===== hw/rtl/atat_lane.sv =====
// One CORDIC lane in vectoring mode: atan2(num, den) in 1/128 degree, saturated.
// Iterates one micro-rotation per cycle, CORDIC_STEPS micro-rotations in all.
// Depends on atat_pkg.
module atat_lane
    import atat_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    num,
    input  logic signed [SUM_W-1:0]    den,
    input  logic                       ack,
    output atat_lane_status_t          status,
    output logic signed [ANGLE_W-1:0]  angle
);

    atat_lane_state_t            state_reg, state_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic signed [CORDIC_W-1:0]  x_reg, x_next;
    logic signed [CORDIC_W-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0]       z_reg, z_next;
    logic                        zero_reg, zero_next;

    logic signed [CORDIC_W-1:0]  x_init, y_init, dx, dy;
    logic signed [Z_W-1:0]       atan_step, z_round, z_shr;

    // Operands scaled by 256
    assign x_init = {{(CORDIC_W-SUM_W-OPER_SHIFT){den[SUM_W-1]}}, den, {OPER_SHIFT{1'b0}}};
    assign y_init = {{(CORDIC_W-SUM_W-OPER_SHIFT){num[SUM_W-1]}}, num, {OPER_SHIFT{1'b0}}};

    // Micro-rotation terms
    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign atan_step = Z_W'(AtanTable[TABLE_IDX_W'(step_reg)]);

    // State and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LANE_IDLE;
        end else begin
            state_reg <= state_next;
        end
        step_reg <= step_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    // Sequencer and iteration
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            LANE_IDLE: begin
                if (start) begin
                    state_next = LANE_RUN;
                    step_next  = '0;
                    zero_next  = (num == '0) && (den == '0);
                    // negative denominator: turn the vector by 180 degrees
                    if (den[SUM_W-1]) begin
                        x_next = -x_init;
                        y_next = -y_init;
                        z_next = num[SUM_W-1] ? -Z_W'(DEG180) : Z_W'(DEG180);
                    end else begin
                        x_next = x_init;
                        y_next = y_init;
                        z_next = '0;
                    end
                end
            end
            LANE_RUN: begin
                if (!y_reg[CORDIC_W-1]) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_step;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_step;
                end
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = LANE_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            LANE_DONE: begin
                if (ack) begin
                    state_next = LANE_IDLE;
                end
            end
            default: begin
                state_next = LANE_IDLE;
            end
        endcase
    end

    // Round to 1/128 degree and saturate
    assign z_round = z_reg + Z_W'(ROUND_BIAS);
    assign z_shr   = z_round >>> ROUND_SHIFT;

    always_comb begin
        if (zero_reg) begin
            angle = '0;
        end else if (z_shr > $signed(Z_W'(ANGLE_LIMIT))) begin
            angle = ANGLE_W'(ANGLE_LIMIT);
        end else if (z_shr < -$signed(Z_W'(ANGLE_LIMIT))) begin
            angle = -ANGLE_W'(ANGLE_LIMIT);
        end else begin
            angle = ANGLE_W'(z_shr);
        end
    end

    assign status.busy = (state_reg == LANE_RUN);
    assign status.done = (state_reg == LANE_DONE);

endmodule

// ===== hw/rtl/atat_merge.sv =====
// Merge stage: collects the three lane angles into the output register.
// Loads when all lanes are done and the output register is free or draining.
// Depends on atat_pkg.
module atat_merge
    import atat_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  atat_lane_status_t          stat_x,
    input  atat_lane_status_t          stat_y,
    input  atat_lane_status_t          stat_z,
    input  logic signed [ANGLE_W-1:0]  angle_x,
    input  logic signed [ANGLE_W-1:0]  angle_y,
    input  logic signed [ANGLE_W-1:0]  angle_z,
    output logic                       lanes_ack,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [3*ANGLE_W-1:0]       m_tdata
);

    logic                  valid_reg, valid_next;
    logic [3*ANGLE_W-1:0]  data_reg, data_next;
    logic                  all_done;

    assign all_done  = stat_x.done && stat_y.done && stat_z.done;
    assign lanes_ack = all_done && (!valid_reg || m_tready);

    // Output register: a new beat may replace one being taken
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (lanes_ack) begin
            valid_next = 1'b1;
            data_next  = {angle_z, angle_y, angle_x};
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== hw/rtl/averaged_accel_tilt_angles_unit.sv =====
// Averaged accelerometer tilt angles: per-axis sums, three CORDIC lanes, merge register.
// A non-final sample is only added to the sums; the final sample of a set starts the lanes,
//   which run CORDIC_STEPS micro-rotations at one per cycle, and the merge register then loads the angles.
// s_tready stays low from then until the merge register takes the angles, longer if m_tready stalls.
// Reset (aresetn low, synchronous): sums and count cleared, sample_count back to 10, no beat out.
// Depends on atat_pkg, atat_lane and atat_merge.
module averaged_accel_tilt_angles_unit
    import atat_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration: sample_count
    input  logic                      cfg_wen,
    input  logic [CFG_W-1:0]          cfg_wdata,
    // samples
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [3*SAMPLE_W-1:0]     s_tdata,   // accel_x, accel_y, accel_z (low bits first)
    // angles
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [3*ANGLE_W-1:0]      m_tdata    // angle_x, angle_y, angle_z (low bits first)
);

    logic [CFG_W-1:0]          cfg_reg;
    logic signed [SUM_W-1:0]   sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0]   sum_x_next, sum_y_next, sum_z_next;
    logic [CNT_W-1:0]          taken_reg, taken_inc, need;
    logic signed [SAMPLE_W-1:0] accel_x, accel_y, accel_z;
    logic                      accept, complete, start, busy, lanes_ack;
    atat_lane_status_t         stat_x, stat_y, stat_z;
    logic signed [ANGLE_W-1:0] angle_x, angle_y, angle_z;

    assign accel_x = s_tdata[SAMPLE_W-1:0];
    assign accel_y = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign accel_z = s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

    // Busy while any lane is rotating or holding a result
    assign busy     = stat_x.busy || stat_x.done || stat_y.busy || stat_y.done
                   || stat_z.busy || stat_z.done;
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    // Samples per set, clamped to 1..MAX_SAMPLES
    always_comb begin
        if (cfg_reg == '0) begin
            need = CNT_W'(1);
        end else if (int'(cfg_reg) > MAX_SAMPLES) begin
            need = CNT_W'(MAX_SAMPLES);
        end else begin
            need = CNT_W'(cfg_reg);
        end
    end

    // Running sums including the current beat, wrapping in SUM_W bits
    assign sum_x_next = sum_x_reg + {{(SUM_W-SAMPLE_W){accel_x[SAMPLE_W-1]}}, accel_x};
    assign sum_y_next = sum_y_reg + {{(SUM_W-SAMPLE_W){accel_y[SAMPLE_W-1]}}, accel_y};
    assign sum_z_next = sum_z_reg + {{(SUM_W-SAMPLE_W){accel_z[SAMPLE_W-1]}}, accel_z};
    assign taken_inc  = taken_reg + 1'b1;
    assign complete   = (taken_inc >= need);
    assign start      = accept && complete;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_W'(CFG_RESET);
        end else if (cfg_wen) begin
            cfg_reg <= cfg_wdata;
        end
    end

    // Accumulators: cleared when a set is handed to the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            taken_reg <= '0;
        end else if (accept) begin
            if (complete) begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_z_reg <= '0;
                taken_reg <= '0;
            end else begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                sum_z_reg <= sum_z_next;
                taken_reg <= taken_inc;
            end
        end
    end

    // Three lanes: atan2(y,z), atan2(x,z), atan2(x,y)
    atat_lane u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .num     (sum_y_next),
        .den     (sum_z_next),
        .ack     (lanes_ack),
        .status  (stat_x),
        .angle   (angle_x)
    );

    atat_lane u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .num     (sum_x_next),
        .den     (sum_z_next),
        .ack     (lanes_ack),
        .status  (stat_y),
        .angle   (angle_y)
    );

    atat_lane u_lane_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .num     (sum_x_next),
        .den     (sum_y_next),
        .ack     (lanes_ack),
        .status  (stat_z),
        .angle   (angle_z)
    );

    // Merge into the output register
    atat_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stat_x    (stat_x),
        .stat_y    (stat_y),
        .stat_z    (stat_z),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z),
        .lanes_ack (lanes_ack),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== hw/rtl/atat_checker.sv =====
// Port-level checks for the averaged accelerometer tilt angle unit, bound to the top level.
// Depends on atat_pkg and averaged_accel_tilt_angles_unit.
module atat_checker
    import atat_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tready,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [3*ANGLE_W-1:0]   m_tdata
);

    // A stalled output beat stays up
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // After reset no result is pending and samples are taken
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the unit");

    // A new result only appears while the lanes hold the sample side off
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a completed set");

    // Every angle lies within plus or minus 180 degrees
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            $signed(m_tdata[15:0])  <= ANGLE_LIMIT && $signed(m_tdata[15:0])  >= -ANGLE_LIMIT &&
            $signed(m_tdata[31:16]) <= ANGLE_LIMIT && $signed(m_tdata[31:16]) >= -ANGLE_LIMIT &&
            $signed(m_tdata[47:32]) <= ANGLE_LIMIT && $signed(m_tdata[47:32]) >= -ANGLE_LIMIT)
        else $error("angle out of range");

endmodule

bind averaged_accel_tilt_angles_unit atat_checker u_atat_checker (.*);
